/* sv/psn_pkg.sv */
package psn_pkg;

  // fixed field widths of the channels and the configuration port
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int DIST_W    = 44;
  localparam int OCOORD_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DSAT_W    = 64;
  localparam int DSHIFT    = 8;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [DIST_W-1:0]   DIST_NONE    = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y = 2'd1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } psn_op_t;

  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    nearest_index;
    logic [DIST_W-1:0]   nearest_dist;
    logic [OCOORD_W-1:0] nearest_x;
    logic [OCOORD_W-1:0] nearest_y;
    logic [CNT_W-1:0]    point_count;
    logic [OCOORD_W-1:0] x_lowest;
    logic [OCOORD_W-1:0] x_highest;
    logic [OCOORD_W-1:0] y_lowest;
    logic [OCOORD_W-1:0] y_highest;
    logic                overflow;
  } psn_res_t;

endpackage

/* sv/psn_in_if.sv */
interface psn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;

  modport source (output valid, output opcode, output x_coord, output y_coord, input ready);
  modport sink (input valid, input opcode, input x_coord, input y_coord, output ready);
endinterface

/* sv/psn_out_if.sv */
interface psn_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [9:0]         nearest_index;
  logic [43:0]        nearest_dist;
  logic signed [15:0] nearest_x;
  logic signed [15:0] nearest_y;
  logic [10:0]        point_count;
  logic signed [15:0] x_lowest;
  logic signed [15:0] x_highest;
  logic signed [15:0] y_lowest;
  logic signed [15:0] y_highest;
  logic               overflow;

  modport source (output valid, output found, output nearest_index, output nearest_dist,
                  output nearest_x, output nearest_y, output point_count, output x_lowest,
                  output x_highest, output y_lowest, output y_highest, output overflow,
                  input ready);
  modport sink (input valid, input found, input nearest_index, input nearest_dist,
                input nearest_x, input nearest_y, input point_count, input x_lowest,
                input x_highest, input y_lowest, input y_highest, input overflow,
                output ready);
endinterface

/* sv/psn_ram.sv */
module psn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* sv/psn_wsq_lane.sv */
// one axis of the distance datapath: difference, magnitude, square, weight
module psn_wsq_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                                      clk,
  input  logic [COORD_BITS-1:0]                     q,
  input  logic [COORD_BITS-1:0]                     p,
  input  logic [psn_pkg::WEIGHT_W-1:0]              w,
  output logic [2*COORD_BITS+psn_pkg::WEIGHT_W-1:0] wsq,
  output logic [COORD_BITS-1:0]                     p_out
);

  localparam int CB    = COORD_BITS;
  localparam int SQ_W  = 2 * CB;
  localparam int WSQ_W = SQ_W + psn_pkg::WEIGHT_W;

  logic signed [CB:0] diff;
  logic signed [CB:0] diff_r;
  logic [CB:0]        neg;
  logic [CB-1:0]      mag_nxt;
  logic [CB-1:0]      mag_r;
  logic [SQ_W-1:0]    sq_r;
  logic [WSQ_W-1:0]   wsq_r;
  logic [CB-1:0]      p1_r, p2_r, p3_r, p4_r;

  always_comb begin
    diff    = $signed({q[CB-1], q}) - $signed({p[CB-1], p});
    neg     = -diff_r;
    mag_nxt = diff_r[CB] ? neg[CB-1:0] : diff_r[CB-1:0];
  end

  always_ff @(posedge clk) begin
    diff_r <= diff;
    mag_r  <= mag_nxt;
    sq_r   <= SQ_W'(mag_r) * SQ_W'(mag_r);
    wsq_r  <= WSQ_W'(sq_r) * WSQ_W'(w);
    p1_r   <= p;
    p2_r   <= p1_r;
    p3_r   <= p2_r;
    p4_r   <= p3_r;
  end

  assign wsq   = wsq_r;
  assign p_out = p4_r;

endmodule

/* sv/psn_best.sv */
// sums both axes and keeps the running minimum, earliest index on ties
module psn_best #(
  parameter int COORD_BITS = 16,
  parameter int IDX_BITS   = 10
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      clr,
  input  logic                                      in_valid,
  input  logic                                      in_last,
  input  logic [IDX_BITS-1:0]                       in_idx,
  input  logic [2*COORD_BITS+psn_pkg::WEIGHT_W-1:0] wsq_x,
  input  logic [2*COORD_BITS+psn_pkg::WEIGHT_W-1:0] wsq_y,
  input  logic [COORD_BITS-1:0]                     px,
  input  logic [COORD_BITS-1:0]                     py,
  output logic                                      done,
  output logic                                      best_found,
  output logic [IDX_BITS-1:0]                       best_idx,
  output logic [psn_pkg::DSAT_W-1:0]                best_dist,
  output logic [COORD_BITS-1:0]                     best_x,
  output logic [COORD_BITS-1:0]                     best_y
);

  localparam int WSQ_W = 2 * COORD_BITS + psn_pkg::WEIGHT_W;
  localparam int SUM_W = WSQ_W + 1;
  localparam int DW    = psn_pkg::DSAT_W;

  logic [SUM_W-1:0]    sum;
  logic [SUM_W+DW-1:0] sum_w;
  logic [DW-1:0]       d_nxt;
  logic                sv_r, slast_r;
  logic [IDX_BITS-1:0] sidx_r;
  logic [DW-1:0]       sd_r;
  logic [COORD_BITS-1:0] sx_r, sy_r;
  logic                found_r;
  logic [IDX_BITS-1:0] bidx_r;
  logic [DW-1:0]       bd_r;
  logic [COORD_BITS-1:0] bx_r, by_r;

  // saturate the exact sum at the top of a 64-bit range
  always_comb begin
    sum   = SUM_W'(wsq_x) + SUM_W'(wsq_y);
    sum_w = {{DW{1'b0}}, sum};
    d_nxt = (|sum_w[SUM_W+DW-1:DW]) ? {DW{1'b1}} : sum_w[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r    <= 1'b0;
      slast_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      sv_r    <= in_valid;
      slast_r <= in_last;
      if (clr) begin
        found_r <= 1'b0;
      end else if (sv_r && (!found_r || sd_r < bd_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= in_idx;
    sd_r   <= d_nxt;
    sx_r   <= px;
    sy_r   <= py;
    if (!clr && sv_r && (!found_r || sd_r < bd_r)) begin
      bidx_r <= sidx_r;
      bd_r   <= sd_r;
      bx_r   <= sx_r;
      by_r   <= sy_r;
    end
  end

  assign done       = sv_r && slast_r;
  assign best_found = found_r;
  assign best_idx   = bidx_r;
  assign best_dist  = bd_r;
  assign best_x     = bx_r;
  assign best_y     = by_r;

endmodule

/* sv/point_store_nearest_search_core.sv */
// Point store with weighted nearest-point search.
// in_ch carries an opcode and a point: append stores the point, clear empties
// the store, query looks for the nearest stored point, opcode 3 does nothing.
// Every transfer on in_ch gives exactly one transfer on out_ch, in order,
// carrying the count and coordinate extremes after that item.
// Append, clear and no-op results go via the result slot to the output register.
// A query on n stored points reads the point memory once per cycle through a
// chain of pipeline cells (difference, magnitude, square, weight, sum, min);
// n is at most MAX_POINTS. A new item is accepted once the previous one has
// finished and its result has moved into the output register, even while
// out_ch stalls; with both the output register and the internal result slot
// full, in_ch ready stays low until out_ch takes a transfer.
// Reset empties the store (count 0, extremes at their sentinels) and sets
// both weights to 1.0; no memory clearing is needed.
// cfg_we writes weight_x (index 0) or weight_y (index 1); write them only while idle, which the block does not enforce.
module point_store_nearest_search_core #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  psn_in_if.sink                           in_ch,
  psn_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [psn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psn_pkg::WEIGHT_W-1:0]     cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int WSQ_W = 2 * CB + psn_pkg::WEIGHT_W;
  localparam int NTAG  = 5;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  typedef struct packed {
    logic          v;
    logic          last;
    logic [AW-1:0] idx;
  } tag_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [CB-1:0] xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic signed [CB-1:0] ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [psn_pkg::WEIGHT_W-1:0] wx_r, wy_r;
  logic [CB-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt, last_addr_r, last_addr_nxt;
  tag_t tag_r [NTAG];
  tag_t tag_in;
  logic pend_valid_r, pend_valid_nxt;
  psn_pkg::psn_res_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  psn_pkg::psn_res_t out_r;

  logic in_ready, in_acc, full, ovf, pend_load, out_load, ram_we, best_clr;
  psn_pkg::psn_op_t op;
  logic [CB+15:0] qx_w, qy_w;
  logic [CB-1:0] qx_in, qy_in;
  logic [CW-1:0] cnt_m1;
  logic [2*CB-1:0] ram_wdata, ram_rdata;
  logic [WSQ_W-1:0] wsq_x, wsq_y;
  logic [CB-1:0] px, py;
  logic best_done, best_found;
  logic [AW-1:0] best_idx;
  logic [psn_pkg::DSAT_W-1:0] best_dist;
  logic [CB-1:0] best_x, best_y;
  logic [psn_pkg::DSAT_W-psn_pkg::DSHIFT-1:0] dsh;
  psn_pkg::psn_res_t res_base;

  function automatic logic [15:0] coord_out(logic [CB-1:0] v);
    logic [CB+15:0] e;
    e = {{16{v[CB-1]}}, v};
    return e[15:0];
  endfunction

  function automatic logic [psn_pkg::CNT_W-1:0] cnt_out(logic [CW-1:0] v);
    logic [CW+psn_pkg::CNT_W-1:0] e;
    e = {{psn_pkg::CNT_W{1'b0}}, v};
    return e[psn_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [psn_pkg::IDX_W-1:0] idx_out(logic [AW-1:0] v);
    logic [AW+psn_pkg::IDX_W-1:0] e;
    e = {{psn_pkg::IDX_W{1'b0}}, v};
    return e[psn_pkg::IDX_W-1:0];
  endfunction

  // input coordinates are taken as COORD_BITS-wide two's complement
  assign qx_w  = {{CB{1'b0}}, in_ch.x_coord};
  assign qy_w  = {{CB{1'b0}}, in_ch.y_coord};
  assign qx_in = qx_w[CB-1:0];
  assign qy_in = qy_w[CB-1:0];

  assign in_ready = (state_r == S_IDLE) && !pend_valid_r;
  assign in_acc   = in_ch.valid && in_ready;
  assign op       = psn_pkg::psn_op_t'(in_ch.opcode);
  assign full     = (count_r == FULL_CNT);
  assign cnt_m1   = count_r - 1'b1;
  assign out_load = pend_valid_r && (!out_valid_r || out_ch.ready);
  assign ram_wdata = {qx_in, qy_in};
  assign dsh      = best_dist[psn_pkg::DSAT_W-1:psn_pkg::DSHIFT];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    scan_addr_nxt = scan_addr_r;
    last_addr_nxt = last_addr_r;
    ovf           = 1'b0;
    ram_we        = 1'b0;
    best_clr      = 1'b0;
    pend_load     = 1'b0;
    tag_in        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_load = 1'b1;
          unique case (op)
            psn_pkg::OP_APPEND: begin
              if (full) begin
                ovf = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if ($signed(qx_in) < xlo_r) xlo_nxt = $signed(qx_in);
                if ($signed(qx_in) > xhi_r) xhi_nxt = $signed(qx_in);
                if ($signed(qy_in) < ylo_r) ylo_nxt = $signed(qy_in);
                if ($signed(qy_in) > yhi_r) yhi_nxt = $signed(qy_in);
              end
            end
            psn_pkg::OP_CLEAR: begin
              count_nxt = '0;
              xlo_nxt   = C_MAX;
              xhi_nxt   = C_MIN;
              ylo_nxt   = C_MAX;
              yhi_nxt   = C_MIN;
            end
            psn_pkg::OP_QUERY: begin
              // empty store answers at once, like a non-query item
              if (count_r != '0) begin
                pend_load     = 1'b0;
                best_clr      = 1'b1;
                qx_nxt        = qx_in;
                qy_nxt        = qy_in;
                scan_addr_nxt = '0;
                last_addr_nxt = cnt_m1[AW-1:0];
                state_nxt     = S_SCAN;
              end
            end
            psn_pkg::OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        tag_in.v      = 1'b1;
        tag_in.last   = (scan_addr_r == last_addr_r);
        tag_in.idx    = scan_addr_r;
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == last_addr_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (best_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        pend_load = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_base               = '0;
    res_base.found         = 1'b0;
    res_base.nearest_dist  = psn_pkg::DIST_NONE;
    res_base.point_count   = cnt_out(count_nxt);
    res_base.x_lowest      = coord_out(xlo_nxt);
    res_base.x_highest     = coord_out(xhi_nxt);
    res_base.y_lowest      = coord_out(ylo_nxt);
    res_base.y_highest     = coord_out(yhi_nxt);
    res_base.overflow      = ovf;

    pend_nxt = res_base;
    if (state_r == S_FIN) begin
      pend_nxt.found         = best_found;
      pend_nxt.nearest_index = idx_out(best_idx);
      pend_nxt.nearest_dist  = (|dsh[psn_pkg::DSAT_W-psn_pkg::DSHIFT-1:psn_pkg::DIST_W]) ?
                               psn_pkg::DIST_NONE : dsh[psn_pkg::DIST_W-1:0];
      pend_nxt.nearest_x     = coord_out(best_x);
      pend_nxt.nearest_y     = coord_out(best_y);
    end

    pend_valid_nxt = pend_valid_r;
    if (pend_load) begin
      pend_valid_nxt = 1'b1;
    end else if (out_load) begin
      pend_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      xlo_r        <= C_MAX;
      xhi_r        <= C_MIN;
      ylo_r        <= C_MAX;
      yhi_r        <= C_MIN;
      wx_r         <= psn_pkg::WEIGHT_RESET;
      wy_r         <= psn_pkg::WEIGHT_RESET;
      scan_addr_r  <= '0;
      last_addr_r  <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NTAG; k++) begin
        tag_r[k] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      xlo_r        <= xlo_nxt;
      xhi_r        <= xhi_nxt;
      ylo_r        <= ylo_nxt;
      yhi_r        <= yhi_nxt;
      scan_addr_r  <= scan_addr_nxt;
      last_addr_r  <= last_addr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == psn_pkg::REG_WEIGHT_X) wx_r <= cfg_data;
        if (cfg_index == psn_pkg::REG_WEIGHT_Y) wy_r <= cfg_data;
      end
      // tags ride alongside the datapath cells, one stage each
      tag_r[0] <= tag_in;
      for (int k = 1; k < NTAG; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    if (pend_load) begin
      pend_r <= pend_nxt;
    end
    if (out_load) begin
      out_r <= pend_r;
    end
  end

  psn_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (state_r == S_SCAN),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  psn_wsq_lane #(.COORD_BITS(CB)) u_lane_x (
    .clk   (clk),
    .q     (qx_r),
    .p     (ram_rdata[2*CB-1:CB]),
    .w     (wx_r),
    .wsq   (wsq_x),
    .p_out (px)
  );

  psn_wsq_lane #(.COORD_BITS(CB)) u_lane_y (
    .clk   (clk),
    .q     (qy_r),
    .p     (ram_rdata[CB-1:0]),
    .w     (wy_r),
    .wsq   (wsq_y),
    .p_out (py)
  );

  psn_best #(.COORD_BITS(CB), .IDX_BITS(AW)) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (best_clr),
    .in_valid   (tag_r[NTAG-1].v),
    .in_last    (tag_r[NTAG-1].last),
    .in_idx     (tag_r[NTAG-1].idx),
    .wsq_x      (wsq_x),
    .wsq_y      (wsq_y),
    .px         (px),
    .py         (py),
    .done       (best_done),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best_dist  (best_dist),
    .best_x     (best_x),
    .best_y     (best_y)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_r.found;
  assign out_ch.nearest_index = out_r.nearest_index;
  assign out_ch.nearest_dist  = out_r.nearest_dist;
  assign out_ch.nearest_x     = out_r.nearest_x;
  assign out_ch.nearest_y     = out_r.nearest_y;
  assign out_ch.point_count   = out_r.point_count;
  assign out_ch.x_lowest      = out_r.x_lowest;
  assign out_ch.x_highest     = out_r.x_highest;
  assign out_ch.y_lowest      = out_r.y_lowest;
  assign out_ch.y_highest     = out_r.y_highest;
  assign out_ch.overflow      = out_r.overflow;

endmodule
